@@ sv/hht_pkg.sv @@
// shared types, constants and the low-bit helper of the hopscotch hash table unit
// no dependencies
`default_nettype none
package hht_pkg;

  localparam int HASH_W  = 32;
  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int CFG_W   = 11;
  localparam int SIG_LSB = 16;

  typedef logic [1:0] req_t;
  localparam req_t REQ_INSERT = 2'd0;
  localparam req_t REQ_LOOKUP = 2'd1;
  localparam req_t REQ_REMOVE = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_BUCKET    = 2'd0;
  localparam status_t ST_CELLAR    = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;
  localparam status_t ST_FULL      = 2'd3;

  typedef logic cfg_idx_t;
  localparam cfg_idx_t REG_BUCKET_COUNT = 1'b0;
  localparam cfg_idx_t REG_CELL_COUNT   = 1'b1;

  localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = 11'd1024;
  localparam logic [6:0]       CELL_COUNT_RST   = 7'd64;

  // index of the lowest set bit, 31 when none is set
  function automatic logic [4:0] low_bit(input logic [31:0] m);
    logic [4:0] b;
    b = 5'd31;
    for (int j = 31; j >= 0; j--) begin
      if (m[j]) b = 5'(j);
    end
    return b;
  endfunction

endpackage
`default_nettype wire

@@ sv/hht_div.sv @@
// iterative restoring remainder unit, one quotient bit per cycle
// depends on hht_pkg
`default_nettype none
module hht_div #(
  parameter int DW = 11
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [hht_pkg::HASH_W-1:0] dividend,
  input  wire logic [DW-1:0]             divisor,
  output logic                           done,
  output logic [DW-1:0]                  rem
);

  localparam int CNT_W = $clog2(hht_pkg::HASH_W);

  logic                       busy_r;
  logic                       done_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [hht_pkg::HASH_W-1:0] dvd_r;
  logic [DW-1:0]              dsr_r;
  logic [DW-1:0]              rem_r;
  logic [DW:0]                trial;
  logic [DW:0]                diff;

  assign trial = {rem_r, dvd_r[hht_pkg::HASH_W-1]};
  assign diff  = trial - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= dividend;
        dsr_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= (trial >= {1'b0, dsr_r}) ? diff[DW-1:0] : trial[DW-1:0];
        dvd_r <= {dvd_r[hht_pkg::HASH_W-2:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(hht_pkg::HASH_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

@@ sv/hopscotch_hash_table_unit.sv @@
// hopscotch hash table unit: sequencer, bucket and cellar memories
// depends on hht_pkg and hht_div
// an item first divides its hash for the home index, then probes buckets or compares
// cells; an insert probes for a free bucket and hops entries toward home, a cellar access
// divides again for its index, and a cellar remove refreshes the home's cellar flag
// items are taken one at a time; the shared remainder unit and the single read port of
// each memory bound the rate
// reset: a clearing pass over all NUM_BUCKETS buckets zeroes maps, flags and occupancy
`default_nettype none
module hopscotch_hash_table_unit #(
  parameter int NUM_BUCKETS    = 1024,
  parameter int NUM_CELLS      = 64,
  parameter int NEIGHBOURHOOD  = 24,
  parameter int SIGNATURE_BITS = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // item in
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [95:0]                in_tdata,  // key_hash, item_key, item_value
  input  wire logic [1:0]                 in_tuser,  // req_type
  // item out
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [31:0]                     out_tdata, // result_value
  output logic [1:0]                      out_tuser, // status
  // configuration writes
  input  wire logic                       cfg_we,
  input  wire hht_pkg::cfg_idx_t          cfg_index,
  input  wire logic [hht_pkg::CFG_W-1:0]  cfg_wdata
);

  localparam int BW  = $clog2(NUM_BUCKETS + 1);
  localparam int BI  = $clog2(NUM_BUCKETS);
  localparam int CW  = $clog2(NUM_CELLS + 1);
  localparam int CI  = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int DW  = (BW > CW) ? BW : CW;
  localparam int MW  = NEIGHBOURHOOD;
  localparam int IW  = $clog2(NEIGHBOURHOOD);
  localparam int SW  = SIGNATURE_BITS;
  localparam int DMW = SW + hht_pkg::KEY_W + hht_pkg::VALUE_W;
  localparam int CMW = hht_pkg::HASH_W + hht_pkg::KEY_W + hht_pkg::VALUE_W;
  localparam int EBW = (BW > hht_pkg::CFG_W) ? BW : hht_pkg::CFG_W;
  localparam int ECW = (CW > 7) ? CW : 7;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_HOME_DIV, S_WAIT,
    S_FIND_HOME, S_FIND_NEXT, S_FIND_CHK,
    S_CELL_DIV, S_CELL_CHK, S_REF_ISSUE, S_REF_CHK, S_REF_DIV,
    S_PROBE_CHK, S_HOP_TEST, S_HOP_NEXT, S_HOP_MAP, S_HOP_SRC, S_HOP_OCC,
    S_FIN_MAP, S_INS_START, S_INS_DIV, S_INS_PROBE, S_DONE
  } state_t;

  // configuration
  logic [hht_pkg::CFG_W-1:0] bucket_count_r;
  logic [6:0]                cell_count_r;
  logic [EBW-1:0]            nb_wide;
  logic [ECW-1:0]            nc_wide;
  logic [BW-1:0]             nb_eff;
  logic [CW-1:0]             nc_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_count_r <= hht_pkg::BUCKET_COUNT_RST;
      cell_count_r   <= hht_pkg::CELL_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        hht_pkg::REG_BUCKET_COUNT: bucket_count_r <= cfg_wdata;
        hht_pkg::REG_CELL_COUNT:   cell_count_r   <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // saturate bucket count to neighbourhood..NUM_BUCKETS, cell count to NUM_CELLS
  always_comb begin
    nb_wide = EBW'(bucket_count_r);
    if (nb_wide < EBW'(NEIGHBOURHOOD)) nb_wide = EBW'(NEIGHBOURHOOD);
    if (nb_wide > EBW'(NUM_BUCKETS))   nb_wide = EBW'(NUM_BUCKETS);
    nb_eff = nb_wide[BW-1:0];
    nc_wide = ECW'(cell_count_r);
    if (nc_wide > ECW'(NUM_CELLS)) nc_wide = ECW'(NUM_CELLS);
    nc_eff = nc_wide[CW-1:0];
  end

  // sequencer registers
  state_t                     state_r, ret_r;
  hht_pkg::req_t              req_r;
  logic [hht_pkg::HASH_W-1:0] hash_r;
  logic [hht_pkg::KEY_W-1:0]  key_r;
  logic [hht_pkg::VALUE_W-1:0] val_r;
  logic [BW-1:0]              nb_r;
  logic [CW-1:0]              nc_r;
  logic [BW-1:0]              home_r;
  logic [BW-1:0]              hole_r;
  logic [BW-1:0]              kb_r;      // bucket probe count
  logic [BW-1:0]              dist_r;
  logic [BW-1:0]              h_r;       // home of the entry being hopped
  logic [BW-1:0]              src_r;
  logic [MW-1:0]              hm_r;      // new map of h_r after the hop
  logic [IW-1:0]              i_r;       // hop distance under test
  logic [MW-1:0]              m_r;       // map bits still to walk
  logic [MW-1:0]              morig_r;
  logic                       flag_r;
  logic [IW-1:0]              bit_r;
  logic [BI-1:0]              b_addr_r;
  logic [CI-1:0]              c_addr_r;
  logic [CW-1:0]              cnt_r;     // cell probe or refresh count
  logic [BI-1:0]              clr_r;
  hht_pkg::status_t           res_st_r;
  logic [hht_pkg::VALUE_W-1:0] res_val_r;
  logic                       out_valid_r;
  hht_pkg::status_t           out_st_r;
  logic [hht_pkg::VALUE_W-1:0] out_val_r;
  logic [NUM_CELLS-1:0]       cocc_r;    // cell occupancy, cleared at reset

  // remainder unit
  logic                       div_start_r;
  logic                       div_start_nxt;
  logic [hht_pkg::HASH_W-1:0] div_dvd_r;
  logic [DW-1:0]              div_dsr_r;
  logic                       div_done;
  logic [DW-1:0]              div_rem;

  hht_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_dvd_r),
    .divisor  (div_dsr_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  // bucket memories: maps and flags per home, occupancy and entry per bucket; cellar entries per cell
  logic [MW-1:0]  map_mem [NUM_BUCKETS];
  logic           flag_mem [NUM_BUCKETS];
  logic           occ_mem [NUM_BUCKETS];
  logic [DMW-1:0] dat_mem [NUM_BUCKETS];
  logic [CMW-1:0] cel_mem [NUM_CELLS];

  logic [MW-1:0]  map_q;
  logic           flag_q;
  logic           occ_q;
  logic [DMW-1:0] dat_q;
  logic [CMW-1:0] cel_q;

  logic           map_we, flag_we, occ_we, dat_we, cel_we;
  logic [BI-1:0]  map_wa, flag_wa, occ_wa, dat_wa;
  logic [MW-1:0]  map_wd;
  logic           flag_wd, occ_wd;
  logic [DMW-1:0] dat_wd;

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    map_q <= map_mem[b_addr_r];
  end
  always_ff @(posedge clk) begin
    if (flag_we) flag_mem[flag_wa] <= flag_wd;
    flag_q <= flag_mem[b_addr_r];
  end
  always_ff @(posedge clk) begin
    if (occ_we) occ_mem[occ_wa] <= occ_wd;
    occ_q <= occ_mem[b_addr_r];
  end
  always_ff @(posedge clk) begin
    if (dat_we) dat_mem[dat_wa] <= dat_wd;
    dat_q <= dat_mem[b_addr_r];
  end
  always_ff @(posedge clk) begin
    if (cel_we) cel_mem[c_addr_r] <= {hash_r, key_r, val_r};
    cel_q <= cel_mem[c_addr_r];
  end

  // fields of the read words
  logic [SW-1:0]               sig_q;
  logic [hht_pkg::KEY_W-1:0]   bkey_q;
  logic [hht_pkg::VALUE_W-1:0] bval_q;
  logic [hht_pkg::HASH_W-1:0]  chash_q;
  logic [hht_pkg::KEY_W-1:0]   ckey_q;
  logic [hht_pkg::VALUE_W-1:0] cval_q;
  logic [SW-1:0]               sig_in;

  assign {sig_q, bkey_q, bval_q}    = dat_q;
  assign {chash_q, ckey_q, cval_q}  = cel_q;
  assign sig_in = hash_r[hht_pkg::SIG_LSB +: SW];

  // ring arithmetic on bucket and cell indexes, one-hot masks and match tests
  logic [IW-1:0]  lb_walk, lb_hop;
  logic [BW:0]    walk_sum, hop_sum, back_sum;
  logic [BW-1:0]  walk_idx, hop_src, back_idx, hole_inc, dist_now;
  logic [CI-1:0]  c_inc;
  logic [CW-1:0]  c_plus;
  logic           bmatch, cmatch, hop_ok;
  logic [MW-1:0]  bit_oh, i_oh, lb_hop_oh, dist_oh;
  logic [4:0]     lb_walk_w, lb_hop_w;

  always_comb begin
    lb_walk_w = hht_pkg::low_bit(32'(m_r));
    lb_hop_w  = hht_pkg::low_bit(32'(map_q));
    lb_walk   = lb_walk_w[IW-1:0];
    lb_hop    = lb_hop_w[IW-1:0];
    walk_sum  = {1'b0, home_r} + (BW + 1)'(lb_walk);
    walk_idx  = (walk_sum >= {1'b0, nb_r}) ? BW'(walk_sum - {1'b0, nb_r}) : walk_sum[BW-1:0];
    hop_sum   = {1'b0, h_r} + (BW + 1)'(lb_hop);
    hop_src   = (hop_sum >= {1'b0, nb_r}) ? BW'(hop_sum - {1'b0, nb_r}) : hop_sum[BW-1:0];
    back_sum  = (hole_r >= BW'(i_r)) ? {1'b0, hole_r} - (BW + 1)'(i_r)
                                     : {1'b0, hole_r} + {1'b0, nb_r} - (BW + 1)'(i_r);
    back_idx  = back_sum[BW-1:0];
    hole_inc  = (hole_r + 1'b1 == nb_r) ? '0 : hole_r + 1'b1;
    dist_now  = (hole_r >= home_r) ? hole_r - home_r : hole_r + nb_r - home_r;
    c_plus    = CW'(c_addr_r) + 1'b1;
    c_inc     = (c_plus == nc_r) ? '0 : c_plus[CI-1:0];
    bit_oh    = MW'(1) << bit_r;
    i_oh      = MW'(1) << i_r;
    lb_hop_oh = MW'(1) << lb_hop;
    dist_oh   = MW'(1) << dist_r;
    hop_ok    = (map_q != '0) && (lb_hop < i_r);
    bmatch    = occ_q && (sig_q == sig_in) && (bkey_q == key_r);
    cmatch    = cocc_r[c_addr_r] && (chash_q == hash_r) && (ckey_q == key_r);
  end

  // memory write strobes follow the sequencer state
  always_comb begin
    map_we  = 1'b0;  map_wa  = home_r[BI-1:0]; map_wd = '0;
    flag_we = 1'b0;  flag_wa = home_r[BI-1:0]; flag_wd = 1'b0;
    occ_we  = 1'b0;  occ_wa  = hole_r[BI-1:0]; occ_wd = 1'b0;
    dat_we  = 1'b0;  dat_wa  = hole_r[BI-1:0]; dat_wd = {sig_in, key_r, val_r};
    cel_we  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        map_we = 1'b1; flag_we = 1'b1; occ_we = 1'b1;
        map_wa = clr_r; flag_wa = clr_r; occ_wa = clr_r;
      end
      S_FIND_CHK: begin
        // removal from a bucket clears the map bit and the occupancy
        if (bmatch && req_r == hht_pkg::REQ_REMOVE) begin
          map_we = 1'b1; map_wd = morig_r & ~bit_oh;
          occ_we = 1'b1; occ_wa = b_addr_r;
        end
      end
      S_REF_ISSUE: begin
        if (cnt_r == nc_r) flag_we = 1'b1;
      end
      S_REF_DIV: begin
        if (div_done && div_rem[BW-1:0] == home_r) begin
          flag_we = 1'b1; flag_wd = 1'b1;
        end
      end
      S_HOP_SRC: begin
        // entry at src moves into the hole
        dat_we = 1'b1; dat_wd = dat_q;
        occ_we = 1'b1; occ_wd = 1'b1;
        map_we = 1'b1; map_wa = h_r[BI-1:0]; map_wd = hm_r;
      end
      S_HOP_OCC: begin
        occ_we = 1'b1; occ_wa = src_r[BI-1:0];
      end
      S_FIN_MAP: begin
        map_we = 1'b1; map_wd = map_q | dist_oh;
        occ_we = 1'b1; occ_wd = 1'b1;
        dat_we = 1'b1;
      end
      S_INS_PROBE: begin
        if (!cocc_r[c_addr_r]) begin
          cel_we = 1'b1; flag_we = 1'b1; flag_wd = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign in_tready = (state_r == S_IDLE);

  // remainder unit is started when leaving these states toward a division
  always_comb begin
    div_start_nxt = 1'b0;
    case (state_r)
      S_IDLE:      div_start_nxt = in_tvalid;
      S_FIND_NEXT: div_start_nxt = (m_r == '0) &&
                                   !((req_r == hht_pkg::REQ_LOOKUP && !flag_r) || nc_r == '0);
      S_REF_CHK:   div_start_nxt = cocc_r[c_addr_r];
      S_INS_START: div_start_nxt = (nc_r != '0);
      default:     div_start_nxt = 1'b0;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ret_r       <= S_IDLE;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
      cocc_r      <= '0;
    end else begin
      div_start_r <= div_start_nxt;
      if (out_valid_r && out_tready && state_r != S_DONE) out_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == BI'(NUM_BUCKETS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_tvalid) begin
            req_r       <= in_tuser;
            hash_r      <= in_tdata[31:0];
            key_r       <= in_tdata[63:32];
            val_r       <= in_tdata[95:64];
            nb_r        <= nb_eff;
            nc_r        <= nc_eff;
            res_val_r   <= '0;
            res_st_r    <= hht_pkg::ST_NOT_FOUND;
            div_dvd_r   <= in_tdata[31:0];
            div_dsr_r   <= DW'(nb_eff);
            state_r     <= S_HOME_DIV;
          end
        end
        S_HOME_DIV: begin
          if (div_done) begin
            home_r   <= div_rem[BW-1:0];
            hole_r   <= div_rem[BW-1:0];
            kb_r     <= '0;
            b_addr_r <= div_rem[BI-1:0];
            case (req_r)
              hht_pkg::REQ_INSERT: begin
                ret_r <= S_PROBE_CHK; state_r <= S_WAIT;
              end
              hht_pkg::REQ_LOOKUP, hht_pkg::REQ_REMOVE: begin
                ret_r <= S_FIND_HOME; state_r <= S_WAIT;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_WAIT: state_r <= ret_r;
        S_FIND_HOME: begin
          m_r     <= map_q;
          morig_r <= map_q;
          flag_r  <= flag_q;
          state_r <= S_FIND_NEXT;
        end
        S_FIND_NEXT: begin
          if (m_r == '0) begin
            // bucket walk exhausted: lookups need the cellar flag
            if ((req_r == hht_pkg::REQ_LOOKUP && !flag_r) || nc_r == '0) begin
              state_r <= S_DONE;
            end else begin
              div_dvd_r   <= hash_r;
              div_dsr_r   <= DW'(nc_r);
              state_r     <= S_CELL_DIV;
            end
          end else begin
            bit_r    <= lb_walk;
            b_addr_r <= walk_idx[BI-1:0];
            ret_r    <= S_FIND_CHK;
            state_r  <= S_WAIT;
          end
        end
        S_FIND_CHK: begin
          if (bmatch) begin
            res_st_r  <= hht_pkg::ST_BUCKET;
            res_val_r <= bval_q;
            state_r   <= S_DONE;
          end else begin
            m_r     <= m_r & (m_r - 1'b1);
            state_r <= S_FIND_NEXT;
          end
        end
        S_CELL_DIV: begin
          if (div_done) begin
            c_addr_r <= div_rem[CI-1:0];
            cnt_r    <= '0;
            ret_r    <= S_CELL_CHK;
            state_r  <= S_WAIT;
          end
        end
        S_CELL_CHK: begin
          if (cmatch) begin
            res_st_r  <= hht_pkg::ST_CELLAR;
            res_val_r <= cval_q;
            if (req_r == hht_pkg::REQ_REMOVE) begin
              cocc_r[c_addr_r] <= 1'b0;
              cnt_r            <= '0;
              state_r          <= S_REF_ISSUE;
            end else begin
              state_r <= S_DONE;
            end
          end else if (cnt_r + 1'b1 == nc_r) begin
            state_r <= S_DONE;
          end else begin
            cnt_r    <= cnt_r + 1'b1;
            c_addr_r <= c_inc;
            ret_r    <= S_CELL_CHK;
            state_r  <= S_WAIT;
          end
        end
        // flag refresh: does any occupied cell still hash to this home
        S_REF_ISSUE: begin
          if (cnt_r == nc_r) begin
            state_r <= S_DONE;
          end else begin
            c_addr_r <= cnt_r[CI-1:0];
            ret_r    <= S_REF_CHK;
            state_r  <= S_WAIT;
          end
        end
        S_REF_CHK: begin
          if (cocc_r[c_addr_r]) begin
            div_dvd_r   <= chash_q;
            div_dsr_r   <= DW'(nb_r);
            state_r     <= S_REF_DIV;
          end else begin
            cnt_r   <= cnt_r + 1'b1;
            state_r <= S_REF_ISSUE;
          end
        end
        S_REF_DIV: begin
          if (div_done) begin
            if (div_rem[BW-1:0] == home_r) begin
              state_r <= S_DONE;
            end else begin
              cnt_r   <= cnt_r + 1'b1;
              state_r <= S_REF_ISSUE;
            end
          end
        end
        // insert: linear probe for an empty bucket
        S_PROBE_CHK: begin
          if (!occ_q) begin
            state_r <= S_HOP_TEST;
          end else if (kb_r + 1'b1 == nb_r) begin
            state_r <= S_INS_START;
          end else begin
            kb_r     <= kb_r + 1'b1;
            hole_r   <= hole_inc;
            b_addr_r <= hole_inc[BI-1:0];
            ret_r    <= S_PROBE_CHK;
            state_r  <= S_WAIT;
          end
        end
        S_HOP_TEST: begin
          dist_r <= dist_now;
          if (dist_now < BW'(NEIGHBOURHOOD)) begin
            b_addr_r <= home_r[BI-1:0];
            ret_r    <= S_FIN_MAP;
            state_r  <= S_WAIT;
          end else begin
            i_r     <= IW'(NEIGHBOURHOOD - 1);
            state_r <= S_HOP_NEXT;
          end
        end
        S_HOP_NEXT: begin
          if (i_r == '0) begin
            state_r <= S_INS_START;
          end else begin
            h_r      <= back_idx;
            b_addr_r <= back_idx[BI-1:0];
            ret_r    <= S_HOP_MAP;
            state_r  <= S_WAIT;
          end
        end
        S_HOP_MAP: begin
          if (hop_ok) begin
            src_r    <= hop_src;
            hm_r     <= (map_q & ~lb_hop_oh) | i_oh;
            b_addr_r <= hop_src[BI-1:0];
            ret_r    <= S_HOP_SRC;
            state_r  <= S_WAIT;
          end else begin
            i_r     <= i_r - 1'b1;
            state_r <= S_HOP_NEXT;
          end
        end
        S_HOP_SRC: state_r <= S_HOP_OCC;
        S_HOP_OCC: begin
          hole_r  <= src_r;
          state_r <= S_HOP_TEST;
        end
        S_FIN_MAP: begin
          res_st_r <= hht_pkg::ST_BUCKET;
          state_r  <= S_DONE;
        end
        // insert fallback into the cellar
        S_INS_START: begin
          if (nc_r == '0) begin
            res_st_r <= hht_pkg::ST_FULL;
            state_r  <= S_DONE;
          end else begin
            div_dvd_r   <= hash_r;
            div_dsr_r   <= DW'(nc_r);
            state_r     <= S_INS_DIV;
          end
        end
        S_INS_DIV: begin
          if (div_done) begin
            c_addr_r <= div_rem[CI-1:0];
            cnt_r    <= '0;
            state_r  <= S_INS_PROBE;
          end
        end
        S_INS_PROBE: begin
          if (!cocc_r[c_addr_r]) begin
            cocc_r[c_addr_r] <= 1'b1;
            res_st_r         <= hht_pkg::ST_CELLAR;
            state_r          <= S_DONE;
          end else if (cnt_r + 1'b1 == nc_r) begin
            res_st_r <= hht_pkg::ST_FULL;
            state_r  <= S_DONE;
          end else begin
            cnt_r    <= cnt_r + 1'b1;
            c_addr_r <= c_inc;
          end
        end
        S_DONE: begin
          // hand the result to the output register once it is free
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_st_r    <= res_st_r;
            out_val_r   <= res_val_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_val_r;
  assign out_tuser  = out_st_r;

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
// self-checking bench for the hopscotch hash table unit: directed table, then random phases
// depends on hht_pkg and hopscotch_hash_table_unit
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

  localparam int NB_MAX = 1024;  // buckets built into the block
  localparam int NC_MAX = 64;    // cellar cells built into the block
  localparam int NBHD   = 24;    // neighbourhood width
  localparam longint CYCLE_LIMIT = 20000000;
  localparam hht_pkg::req_t REQ_SPARE = 2'd3;  // unused request code

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  logic                      in_tvalid = 1'b0;
  logic                      in_tready;
  logic [95:0]               in_tdata = '0;   // key_hash, item_key, item_value
  logic [1:0]                in_tuser = '0;   // req_type
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [31:0]               out_tdata;       // result_value
  logic [1:0]                out_tuser;       // status
  logic                      cfg_we = 1'b0;
  hht_pkg::cfg_idx_t         cfg_index = hht_pkg::REG_BUCKET_COUNT;
  logic [hht_pkg::CFG_W-1:0] cfg_wdata = '0;

  hopscotch_hash_table_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // table mirror: our own copy of buckets, maps, flags and cellar
  // ---------------------------------------------------------------------------
  logic [23:0]  m_map    [NB_MAX];
  logic [7:0]   m_sig    [NB_MAX];
  bit           m_cflag  [NB_MAX];
  bit           m_occ    [NB_MAX];
  logic [31:0]  m_key    [NB_MAX];
  logic [31:0]  m_val    [NB_MAX];
  bit           c_occ    [NC_MAX];
  logic [31:0]  c_hash   [NC_MAX];
  logic [31:0]  c_key    [NC_MAX];
  logic [31:0]  c_val    [NC_MAX];
  int unsigned  bucket_reg = 32'(hht_pkg::BUCKET_COUNT_RST);
  int unsigned  cell_reg   = 32'(hht_pkg::CELL_COUNT_RST);

  typedef struct packed {
    hht_pkg::status_t status;
    logic [31:0]      value;
  } table_reply_t;

  table_reply_t pending_replies[$];

  int  errors = 0;
  int  items_sent = 0;
  int  replies_seen = 0;
  int  status_hits[4] = '{0, 0, 0, 0};
  int  idle_pct = 0;    // sender idle chance per cycle
  int  stall_pct = 0;   // receiver stall chance per cycle
  longint cycles = 0;

  // register values are saturated to what the block holds
  function automatic int unsigned buckets_used();
    if (bucket_reg < NBHD) return NBHD;
    if (bucket_reg > NB_MAX) return NB_MAX;
    return bucket_reg;
  endfunction

  function automatic int unsigned cells_used();
    return (cell_reg > NC_MAX) ? NC_MAX : cell_reg;
  endfunction

  function automatic int unsigned lowest_set(logic [23:0] m);
    for (int j = 0; j < 24; j++) if (m[j]) return j;
    return 31;
  endfunction

  // pull one earlier entry into the hole so the hole moves nearer home
  task automatic hop_toward_home(inout int unsigned hole, input int unsigned nb,
                                 output bit moved);
    int unsigned hb, b, src;
    logic [23:0] m;
    moved = 1'b0;
    for (int unsigned i = NBHD - 1; i != 0; i--) begin
      hb = (hole + nb - (i % nb)) % nb;
      m = m_map[hb];
      if (m == 0) continue;
      b = lowest_set(m);
      if (b < i) begin
        src = (hb + b) % nb;
        m_key[hole] = m_key[src];
        m_val[hole] = m_val[src];
        m_sig[hole] = m_sig[src];
        m_occ[hole] = 1'b1;
        m_map[hb] = (m & ~(24'd1 << b)) | (24'd1 << i);
        m_occ[src] = 1'b0;
        hole = src;
        moved = 1'b1;
        return;
      end
    end
  endtask

  task automatic place_in_buckets(input logic [31:0] h, k, v, output bit ok);
    int unsigned nb, home, hole, k_probe;
    bit moved;
    nb = buckets_used();
    home = h % nb;
    hole = home;
    ok = 1'b0;
    for (k_probe = 0; k_probe < nb; k_probe++) begin
      if (!m_occ[hole]) break;
      hole = (hole + 1) % nb;
    end
    if (k_probe == nb) return;
    while (((hole + nb - home) % nb) >= NBHD) begin
      hop_toward_home(hole, nb, moved);
      if (!moved) return;   // hops made so far stay in place
    end
    m_occ[hole] = 1'b1;
    m_key[hole] = k;
    m_val[hole] = v;
    m_sig[hole] = h[hht_pkg::SIG_LSB +: 8];
    m_map[home][(hole + nb - home) % nb] = 1'b1;
    ok = 1'b1;
  endtask

  task automatic place_in_cellar(input logic [31:0] h, k, v, output bit ok);
    int unsigned nc, idx;
    nc = cells_used();
    ok = 1'b0;
    if (nc == 0) return;
    idx = h % nc;
    for (int unsigned p = 0; p < nc; p++) begin
      if (!c_occ[idx]) begin
        c_occ[idx] = 1'b1;
        c_hash[idx] = h;
        c_key[idx] = k;
        c_val[idx] = v;
        m_cflag[h % buckets_used()] = 1'b1;
        ok = 1'b1;
        return;
      end
      idx = (idx + 1) % nc;
    end
  endtask

  // walk the home map from the low bit up; -1 when no bucket matches
  function automatic int search_buckets(logic [31:0] h, k, output int unsigned hit_bit);
    int unsigned nb, home, b, idx;
    logic [23:0] m;
    nb = buckets_used();
    home = h % nb;
    m = m_map[home];
    hit_bit = 0;
    while (m != 0) begin
      b = lowest_set(m);
      idx = (home + b) % nb;
      if (m_occ[idx] && m_sig[idx] == h[hht_pkg::SIG_LSB +: 8] && m_key[idx] == k) begin
        hit_bit = b;
        return idx;
      end
      m[b] = 1'b0;
    end
    return -1;
  endfunction

  function automatic int probe_cells(logic [31:0] h, k);
    int unsigned nc, idx;
    nc = cells_used();
    if (nc == 0) return -1;
    idx = h % nc;
    for (int unsigned p = 0; p < nc; p++) begin
      if (c_occ[idx] && c_hash[idx] == h && c_key[idx] == k) return idx;
      idx = (idx + 1) % nc;
    end
    return -1;
  endfunction

  // apply one request to the mirror and return the reply it should produce
  task automatic apply_request(input hht_pkg::req_t r, input logic [31:0] h, k, v,
                               output table_reply_t rep);
    int at;
    int unsigned hb, home, nb;
    bit ok;
    rep.status = hht_pkg::ST_NOT_FOUND;
    rep.value = '0;
    nb = buckets_used();
    home = h % nb;
    case (r)
      hht_pkg::REQ_INSERT: begin
        place_in_buckets(h, k, v, ok);
        if (ok) rep.status = hht_pkg::ST_BUCKET;
        else begin
          place_in_cellar(h, k, v, ok);
          rep.status = ok ? hht_pkg::ST_CELLAR : hht_pkg::ST_FULL;
        end
      end
      hht_pkg::REQ_LOOKUP: begin
        at = search_buckets(h, k, hb);
        if (at >= 0) begin
          rep.status = hht_pkg::ST_BUCKET;
          rep.value = m_val[at];
        end else if (m_cflag[home]) begin
          at = probe_cells(h, k);
          if (at >= 0) begin
            rep.status = hht_pkg::ST_CELLAR;
            rep.value = c_val[at];
          end
        end
      end
      hht_pkg::REQ_REMOVE: begin
        at = search_buckets(h, k, hb);
        if (at >= 0) begin
          m_map[home][hb] = 1'b0;
          m_occ[at] = 1'b0;
          rep.status = hht_pkg::ST_BUCKET;
          rep.value = m_val[at];
        end else begin
          at = probe_cells(h, k);
          if (at >= 0) begin
            c_occ[at] = 1'b0;
            // flag stays only if another live cell still maps to this home
            m_cflag[home] = 1'b0;
            for (int unsigned i = 0; i < cells_used(); i++)
              if (c_occ[i] && c_hash[i] % nb == home) m_cflag[home] = 1'b1;
            rep.status = hht_pkg::ST_CELLAR;
            rep.value = c_val[at];
          end
        end
      end
      default: ;   // unused code: nothing changes
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // driving side
  // ---------------------------------------------------------------------------
  // present one item, wait for the handshake, then queue what it should return;
  // a typed reply, when given, replaces the mirror's answer
  task automatic send_item(input hht_pkg::req_t r, input logic [31:0] h, k, v,
                           input bit typed, input table_reply_t typed_rep,
                           output table_reply_t rep);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= r;
    in_tdata <= {v, k, h};
    do @(posedge clk); while (!in_tready);
    apply_request(r, h, k, v, rep);
    if (typed) rep = typed_rep;
    pending_replies.push_back(rep);
    items_sent++;
  endtask

  task automatic write_reg(input hht_pkg::cfg_idx_t idx, input int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[hht_pkg::CFG_W-1:0];
    @(posedge clk);
    if (idx == hht_pkg::REG_BUCKET_COUNT) bucket_reg = val & 11'h7FF;
    else cell_reg = val & 7'h7F;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // receiver stalls are redrawn every cycle
  always @(negedge clk) out_tready <= ($urandom_range(0, 99) >= stall_pct);

  // ---------------------------------------------------------------------------
  // checking side
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    table_reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      replies_seen++;
      if (pending_replies.size() == 0) begin
        $error("unexpected item: status %0d value %h", out_tuser, out_tdata);
        errors++;
      end else begin
        want = pending_replies.pop_front();
        status_hits[out_tuser]++;
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tuser);
          errors++;
        end
        if (out_tdata !== want.value) begin
          $error("result_value: expected %h, got %h", want.value, out_tdata);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycles,
               pending_replies.size());
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // directed rows: fresh table, 1024 buckets, 64 cells
  // ---------------------------------------------------------------------------
  typedef struct {
    hht_pkg::req_t    r;
    logic [31:0]      h, k, v;
    bit               typed;
    hht_pkg::status_t st;
    logic [31:0]      val;
  } table_row_t;

  localparam int N_ROWS = 15;
  table_row_t rows[N_ROWS] = '{
    // lookups and removes on an empty table
    '{hht_pkg::REQ_LOOKUP, 32'h0, 32'h0, 32'h0, 1, hht_pkg::ST_NOT_FOUND, 32'h0},
    '{hht_pkg::REQ_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1, hht_pkg::ST_NOT_FOUND,
      32'h0},
    // unused request code
    '{REQ_SPARE, 32'h0, 32'h0, 32'h0, 1, hht_pkg::ST_NOT_FOUND, 32'h0},
    // extremes of every field, insert always returns zero
    '{hht_pkg::REQ_INSERT, 32'h0, 32'h0, 32'hFFFF_FFFF, 1, hht_pkg::ST_BUCKET, 32'h0},
    '{hht_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1, hht_pkg::ST_BUCKET, 32'h0},
    '{hht_pkg::REQ_LOOKUP, 32'h0, 32'h0, 32'h0, 1, hht_pkg::ST_BUCKET, 32'hFFFF_FFFF},
    '{hht_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, hht_pkg::ST_BUCKET,
      32'h0},
    // duplicate key stored again
    '{hht_pkg::REQ_INSERT, 32'h0, 32'h0, 32'h1234_5678, 1, hht_pkg::ST_BUCKET, 32'h0},
    '{hht_pkg::REQ_LOOKUP, 32'h0, 32'h0, 32'h0, 0, hht_pkg::ST_BUCKET, 32'h0},
    // same home, other signature
    '{hht_pkg::REQ_LOOKUP, 32'h00FF_0000, 32'h0, 32'h0, 1, hht_pkg::ST_NOT_FOUND, 32'h0},
    '{hht_pkg::REQ_REMOVE, 32'h0, 32'h0, 32'h0, 0, hht_pkg::ST_BUCKET, 32'h0},
    '{hht_pkg::REQ_REMOVE, 32'h0, 32'h0, 32'h0, 0, hht_pkg::ST_BUCKET, 32'h0},
    '{hht_pkg::REQ_REMOVE, 32'h0, 32'h0, 32'h0, 1, hht_pkg::ST_NOT_FOUND, 32'h0},
    '{REQ_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, hht_pkg::ST_NOT_FOUND, 32'h0},
    '{hht_pkg::REQ_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 0, hht_pkg::ST_BUCKET, 32'h0}
  };

  // random phases: register values (extremes included) and a live-entry target
  localparam int N_PHASES = 8;
  int unsigned ph_buckets[N_PHASES] = '{0,   24, 2047, 40, 30, 1024, 25, 100};
  int unsigned ph_cells  [N_PHASES] = '{0,   1,  127,  8,  64, 64,   0,  3};
  int unsigned ph_target [N_PHASES] = '{60,  40, 50,   45, 90, 60,   30, 110};

  logic [31:0] live_hash[$];
  logic [31:0] live_key[$];

  task automatic drain_and_settle();
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    table_reply_t rep, none;
    hht_pkg::req_t r;
    logic [31:0] h, k, v, hbase;
    int unsigned nb, pick, roll;
    int pool_key;
    none = '0;
    for (int i = 0; i < NB_MAX; i++) begin
      m_map[i] = '0; m_cflag[i] = 0; m_occ[i] = 0;
    end
    for (int i = 0; i < NC_MAX; i++) c_occ[i] = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part
    foreach (rows[i])
      send_item(rows[i].r, rows[i].h, rows[i].k, rows[i].v, rows[i].typed,
                '{rows[i].st, rows[i].val}, rep);

    for (int p = 0; p < N_PHASES; p++) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      drain_and_settle();
      write_reg(hht_pkg::REG_BUCKET_COUNT, ph_buckets[p]);
      write_reg(hht_pkg::REG_CELL_COUNT, ph_cells[p]);
      // idling pattern cycles through none / sender / receiver / both
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 82; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 82; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      nb = buckets_used();
      hbase = $urandom();
      for (int n = 0; n < 180; n++) begin
        // homes clustered in a narrow band so neighbourhoods fill and hops happen
        h = $urandom();
        if ($urandom_range(0, 9) != 0)
          h = h - (h % nb) + ((hbase + $urandom_range(0, 9)) % nb);
        k = $urandom();
        v = $urandom();
        roll = $urandom_range(0, 99);
        pool_key = (live_key.size() != 0);
        if (roll < 4) begin
          r = REQ_SPARE;   // noise
        end else if (roll < ((live_key.size() < ph_target[p]) ? 60 : 30)) begin
          r = hht_pkg::REQ_INSERT;
          if (pool_key && $urandom_range(0, 7) == 0) begin
            pick = $urandom_range(0, live_key.size() - 1);
            h = live_hash[pick];
            k = live_key[pick];   // duplicate
          end
        end else begin
          r = ($urandom_range(0, 1) != 0) ? hht_pkg::REQ_LOOKUP : hht_pkg::REQ_REMOVE;
          if (pool_key && $urandom_range(0, 9) < 8) begin
            pick = $urandom_range(0, live_key.size() - 1);
            h = live_hash[pick];
            k = live_key[pick];
            if ($urandom_range(0, 9) == 0) begin
              h[hht_pkg::SIG_LSB +: 8] = ~h[hht_pkg::SIG_LSB +: 8];
            end else if (r == hht_pkg::REQ_REMOVE) begin
              live_hash.delete(pick);
              live_key.delete(pick);
            end
          end
        end
        send_item(r, h, k, v, 0, none, rep);
        if (r == hht_pkg::REQ_INSERT && rep.status != hht_pkg::ST_FULL) begin
          live_hash.push_back(h);
          live_key.push_back(k);
        end
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    drain_and_settle();

    $display("%0d items sent, %0d replies: %0d bucket, %0d cellar, %0d not found, %0d full",
             items_sent, replies_seen, status_hits[0], status_hits[1], status_hits[2],
             status_hits[3]);
    $display("%0d register settings from saturated low to saturated high, %0d mismatches",
             2 * N_PHASES, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
